// ----- rtl/md5_stream_hash_assert.svh -----
// ----------------------------------------------------------------------------
// md5_stream_hash_assert
// Assertion macros used by the MD5 stream hasher controller.
// ----------------------------------------------------------------------------
`ifndef MD5_STREAM_HASH_ASSERT_SVH
`define MD5_STREAM_HASH_ASSERT_SVH
// implication checked each cycle outside reset
`define MD5_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("md5 assertion failed");
// next-cycle implication
`define MD5_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("md5 assertion failed");
`endif

// ----- rtl/md5_pkg.sv -----
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and the message index function for the MD5 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package md5_pkg;
   localparam int unsigned BlockBytes = 64;
   localparam int unsigned PosBits    = 6;
   localparam int unsigned WordIdxBits = 4;
   localparam logic [31:0] InitA = 32'h67452301;
   localparam logic [31:0] InitB = 32'hefcdab89;
   localparam logic [31:0] InitC = 32'h98badcfe;
   localparam logic [31:0] InitD = 32'h10325476;
   localparam logic [7:0]  PadByte = 8'h80;
   localparam logic [5:0]  LenPos  = 6'd56;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic       wr_en;
      logic [5:0] wr_addr;
      logic [7:0] wr_data;
      logic       start;      // load a..d from chaining words, round 0
      logic       round;      // one round
      logic       fold;       // add a..d into chaining words
      logic       init;       // chaining words back to initial values
      logic [5:0] rnd;        // current round number
   } dp_cmd_type;

   localparam logic [31:0] RoundK [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] RotAmt [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   function automatic logic [3:0] msg_pick(input logic [5:0] i);
      logic [7:0] t;
      begin
         t = 8'd0;
         unique case (i[5:4])
            2'd0: t = {2'b00, i};
            2'd1: t = ({2'b00, i} * 8'd5) + 8'd1;
            2'd2: t = ({2'b00, i} * 8'd3) + 8'd5;
            2'd3: t = {2'b00, i} * 8'd7;
         endcase
         return t[3:0];
      end
   endfunction
endpackage
`default_nettype wire

// ----- rtl/md5_datapath.sv -----
// ----------------------------------------------------------------------------
// md5_datapath
// Block buffer, chaining words and the one-round-per-cycle compression unit.
// ----------------------------------------------------------------------------
`default_nettype none
module md5_datapath
   import md5_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire dp_cmd_type cmd,
   output logic [31:0]     chain_out [4]
);
   // buffer as 16 little-endian words, written bytewise
   logic [31:0] buf_ff [16];
   logic [31:0] h_ff [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] a_in, b_in, c_in, d_in;
   logic [31:0] ra, rb, rc, rd, mix, sum, rot;
   logic [4:0]  sh;
   logic [5:0]  rn;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         buf_ff[cmd.wr_addr[5:2]][8*cmd.wr_addr[1:0] +: 8] <= cmd.wr_data;
      end
   end

   always_comb begin
      rn = cmd.rnd;
      if (cmd.start) begin
         ra = h_ff[0]; rb = h_ff[1]; rc = h_ff[2]; rd = h_ff[3];
      end else begin
         ra = a_ff; rb = b_ff; rc = c_ff; rd = d_ff;
      end
      mix = '0;
      unique case (rn[5:4])
         2'd0: mix = (rb & rc) | (~rb & rd);
         2'd1: mix = (rb & rd) | (rc & ~rd);
         2'd2: mix = rb ^ rc ^ rd;
         2'd3: mix = rc ^ (rb | ~rd);
      endcase
      sum = ra + mix + RoundK[rn] + buf_ff[msg_pick(rn)];
      sh  = RotAmt[{rn[5:4], rn[1:0]}];
      rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
      a_in = rd;
      d_in = rc;
      c_in = rb;
      b_in = rb + rot;
   end

   always_ff @(posedge clock) begin
      if (cmd.start || cmd.round) begin
         a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.init) begin
         h_ff[0] <= InitA; h_ff[1] <= InitB; h_ff[2] <= InitC; h_ff[3] <= InitD;
      end else if (cmd.fold) begin
         h_ff[0] <= h_ff[0] + a_ff;
         h_ff[1] <= h_ff[1] + b_ff;
         h_ff[2] <= h_ff[2] + c_ff;
         h_ff[3] <= h_ff[3] + d_ff;
      end
   end

   assign chain_out = h_ff;
endmodule
`default_nettype wire

// ----- rtl/md5_ctrl.sv -----
// ----------------------------------------------------------------------------
// md5_ctrl
// Sequencer: byte intake, padding, round count and digest output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "md5_stream_hash_assert.svh"
module md5_ctrl
   import md5_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   output dp_cmd_type   cmd,
   input  wire logic [31:0] chain_in [4]
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PAD  = 3'd1;  // zero fill up to length field or block end
   localparam logic [2:0] ST_LEN  = 3'd2;  // write 8 length bytes
   localparam logic [2:0] ST_RUN  = 3'd3;  // 64 rounds
   localparam logic [2:0] ST_FOLD = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [63:0] cnt_ff, cnt_in;
   logic [5:0]  pos_ff, pos_in;     // fill/write pointer
   logic [5:0]  rnd_ff, rnd_in;
   logic        fin_ff, fin_in;     // finishing message
   logic        lenok_ff, lenok_in; // length already placed in this block
   logic [1:0]  idx_ff, idx_in;
   logic        pend_ff, pend_in;   // another block follows after fold

   wire req_fire = req_valid && req_ready;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data.digest_word = chain_in[idx_ff];
   assign rsp_data.word_index  = idx_ff;
   assign rsp_data.last        = (idx_ff == 2'd3);

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; pos_in = pos_ff; rnd_in = rnd_ff;
      fin_in = fin_ff; lenok_in = lenok_ff; idx_in = idx_ff; pend_in = pend_ff;
      cmd = '0;
      cmd.rnd = rnd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd.wr_en = 1'b1;
               cmd.wr_addr = pos_ff;
               pos_in = pos_ff + 6'd1;
               if (!req_data.mode) begin
                  cmd.wr_data = req_data.data_byte;
                  cnt_in = cnt_ff + 64'd8;
                  if (pos_ff == 6'd63) begin
                     state_in = ST_RUN; rnd_in = '0; fin_in = 1'b0;
                  end
               end else begin
                  cmd.wr_data = PadByte;
                  fin_in = 1'b1;
                  lenok_in = 1'b0;
                  if (pos_ff == 6'd63) begin
                     state_in = ST_RUN; rnd_in = '0; pend_in = 1'b1;
                  end else if (pos_ff + 6'd1 == LenPos) begin
                     state_in = ST_LEN;
                  end else begin
                     state_in = ST_PAD;
                  end
               end
            end
         end
         ST_PAD: begin
            cmd.wr_en = 1'b1; cmd.wr_addr = pos_ff; cmd.wr_data = '0;
            pos_in = pos_ff + 6'd1;
            if (pos_ff == 6'd63) begin
               state_in = ST_RUN; rnd_in = '0; pend_in = 1'b1;
            end else if (pos_ff + 6'd1 == LenPos && !pend_ff) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            cmd.wr_en = 1'b1; cmd.wr_addr = pos_ff;
            cmd.wr_data = cnt_ff[8*pos_ff[2:0] +: 8];
            pos_in = pos_ff + 6'd1;
            if (pos_ff == 6'd63) begin
               state_in = ST_RUN; rnd_in = '0; lenok_in = 1'b1; pend_in = 1'b0;
            end
         end
         ST_RUN: begin
            cmd.start = (rnd_ff == 6'd0);
            cmd.round = (rnd_ff != 6'd0);
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (pend_ff) begin
               // tail too long: second block of zeros plus length
               pend_in = 1'b0; pos_in = '0; state_in = ST_PAD;
            end else begin
               state_in = ST_OUT; idx_in = '0;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  cmd.init = 1'b1; state_in = ST_IDLE; cnt_in = '0; pos_in = '0;
                  fin_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; cnt_ff <= '0; pos_ff <= '0; rnd_ff <= '0;
         fin_ff <= 1'b0; lenok_ff <= 1'b0; idx_ff <= '0; pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; pos_ff <= pos_in; rnd_ff <= rnd_in;
         fin_ff <= fin_in; lenok_ff <= lenok_in; idx_ff <= idx_in; pend_ff <= pend_in;
      end
   end

   `MD5_ASSERT_IMP(a_fill_tracks_count, clock, reset, state_ff == ST_IDLE, pos_ff == cnt_ff[8:3])
   `MD5_ASSERT_NEXT(a_run_after_last, clock, reset, state_ff == ST_RUN && rnd_ff == 6'd63, state_ff == ST_FOLD)
   `MD5_ASSERT_IMP(a_out_only_fin, clock, reset, state_ff == ST_OUT, fin_ff && lenok_ff)
endmodule
`default_nettype wire

// ----- rtl/md5_stream_hash.sv -----
// ----------------------------------------------------------------------------
// md5_stream_hash
// Streaming MD5 digest engine, top level.
// ----------------------------------------------------------------------------
// Usage:
//  req channel: one byte per handshake, mode 0 absorbs data_byte, mode 1 ends
//  the message. rsp channel: four digest words, index 0..3, last on index 3.
//  The 64th byte of a block starts the compression (one MD5 round per cycle on
//  a single round unit, then a fold), during which req_ready is low.
//  A finish writes the pad and length bytes one per cycle, runs one or two
//  compressions, then offers the four digest words, one per cycle while
//  rsp_ready is high.
//  Reset returns chaining words and bit count to the initial state; the
//  buffer needs no clearing. While the receiver stalls the digest word holds
//  and no new request is taken. After the last digest word the engine is
//  back in its initial state for the next message.
// ----------------------------------------------------------------------------
`default_nettype none
module md5_stream_hash
   import md5_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);
   dp_cmd_type  cmd;
   logic [31:0] chain [4];

   md5_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .cmd, .chain_in(chain)
   );

   md5_datapath u_dp (
      .clock, .reset, .cmd, .chain_out(chain)
   );
endmodule
`default_nettype wire
